FILE: src/assert_macros.svh
// assertion macros for the line follow steering datapath
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

FILE: src/lfp_pkg.sv
// shared types, constants and the arctangent table of the steering block
package lfp_pkg;

   // field widths
   localparam int SENSOR_W   = 8;
   localparam int DRIVE_W    = 10;
   localparam int ANGLE_W    = 13;
   localparam int GAIN_W     = 6;
   localparam int THRESH_W   = 3;
   localparam int COUNT_W    = 4;
   localparam int SUM_W      = 5;

   // internal datapath widths
   localparam int CORDIC_W   = 30;
   localparam int Z_W        = 25;
   localparam int DANG_W     = ANGLE_W + 1;
   localparam int PPROD_W    = GAIN_W + 1 + ANGLE_W;
   localparam int DPROD_W    = GAIN_W + 1 + DANG_W;
   localparam int PD_W       = 22;
   localparam int DELTA_W    = 14;
   localparam int WIDE_W     = 16;

   localparam int CORDIC_STEPS = 16;
   localparam int ITER_W       = $clog2(CORDIC_STEPS);

   localparam int ANGLE_LIMIT = 3072;
   localparam int DRIVE_LIMIT = 400;

   // configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 10;

   localparam logic [CSR_IDX_W-1:0] REG_BASE_SPEED    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_GAIN_P        = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_GAIN_D        = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_JUNCTION_THR  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_REVERSE_BITS  = 3'd4;

   typedef struct packed {
      logic [DRIVE_W-1:0]  base_speed;
      logic [GAIN_W-1:0]   gain_p;
      logic [GAIN_W-1:0]   gain_d;
      logic [THRESH_W-1:0] junction_threshold;
      logic                reverse_bits;
   } lfp_cfg_type;

   typedef struct packed {
      logic              start;
      logic              init;
      logic              step;
      logic              round;
      logic              mul;
      logic              div;
      logic              load_out;
      logic [ITER_W-1:0] iter;
   } lfp_cmd_type;

   typedef struct packed {
      logic out_busy;
   } lfp_status_type;

   // atan(2^-i) in 1/65536 degree
   function automatic logic [Z_W-1:0] atan_entry(input logic [ITER_W-1:0] idx);
      logic [Z_W-1:0] v;
      case (idx)
         4'd0:    v = 25'd2949120;
         4'd1:    v = 25'd1740967;
         4'd2:    v = 25'd919879;
         4'd3:    v = 25'd466945;
         4'd4:    v = 25'd234379;
         4'd5:    v = 25'd117304;
         4'd6:    v = 25'd58666;
         4'd7:    v = 25'd29335;
         4'd8:    v = 25'd14668;
         4'd9:    v = 25'd7334;
         4'd10:   v = 25'd3667;
         4'd11:   v = 25'd1833;
         4'd12:   v = 25'd917;
         4'd13:   v = 25'd458;
         4'd14:   v = 25'd229;
         4'd15:   v = 25'd115;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

FILE: src/line_follow_pd_steering.sv
// top level of the line follow pd steering block
//
//   channel  ports                                   direction
//   request  req_valid req_ready req_sensor_bits     in
//   response rsp_valid rsp_ready rsp_* fields        out
//   config   csr_we csr_index csr_wdata              in, write only
//
// a request passes from acceptance through a setup state, the iterations of the
// single shared cordic shift-add step, then rounding, multiply, divide and output
// states; the next request is accepted only after the output state.
// reset is synchronous and active high; it clears the heading history and
// loads the register defaults. a response held by rsp_ready low stalls the
// block in its output cycle; the next request is still taken while the
// finished response waits.
module line_follow_pd_steering
   import lfp_pkg::*;
#(
   parameter int SENSOR_COUNT = 7
)(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [SENSOR_W-1:0]        req_sensor_bits,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic signed [DRIVE_W-1:0]  rsp_left_drive,
   output logic signed [DRIVE_W-1:0]  rsp_right_drive,
   output logic signed [ANGLE_W-1:0]  rsp_angle_error,
   output logic                       rsp_junction_seen,
   output logic                       rsp_left_branch,
   output logic                       rsp_right_branch,
   output logic                       rsp_no_line,
   input  logic                       csr_we,
   input  logic [CSR_IDX_W-1:0]       csr_index,
   input  logic [CSR_DATA_W-1:0]      csr_wdata
);

   lfp_cfg_type    cfg;
   lfp_cmd_type    cmd;
   lfp_status_type status;

   // configuration registers
   lfp_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // sequencer
   lfp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // arithmetic
   lfp_dp #(
      .SENSOR_COUNT (SENSOR_COUNT)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg),
      .cmd               (cmd),
      .status            (status),
      .req_sensor_bits   (req_sensor_bits),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_left_drive    (rsp_left_drive),
      .rsp_right_drive   (rsp_right_drive),
      .rsp_angle_error   (rsp_angle_error),
      .rsp_junction_seen (rsp_junction_seen),
      .rsp_left_branch   (rsp_left_branch),
      .rsp_right_branch  (rsp_right_branch),
      .rsp_no_line       (rsp_no_line)
   );

endmodule

FILE: src/lfp_csr.sv
// configuration registers of the steering block
module lfp_csr
   import lfp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output lfp_cfg_type           cfg
);

   lfp_cfg_type cfg_ff;

   // register writes, unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.base_speed         <= 10'h36A;
         cfg_ff.gain_p             <= 6'd12;
         cfg_ff.gain_d             <= 6'd20;
         cfg_ff.junction_threshold <= 3'd3;
         cfg_ff.reverse_bits       <= 1'b1;
      end else if (csr_we) begin
         case (csr_index)
            REG_BASE_SPEED:   cfg_ff.base_speed         <= csr_wdata[DRIVE_W-1:0];
            REG_GAIN_P:       cfg_ff.gain_p             <= csr_wdata[GAIN_W-1:0];
            REG_GAIN_D:       cfg_ff.gain_d             <= csr_wdata[GAIN_W-1:0];
            REG_JUNCTION_THR: cfg_ff.junction_threshold <= csr_wdata[THRESH_W-1:0];
            REG_REVERSE_BITS: cfg_ff.reverse_bits       <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

FILE: src/lfp_ctrl.sv
// sequencing state machine of the steering block
module lfp_ctrl
   import lfp_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   input  lfp_status_type status,
   output lfp_cmd_type    cmd
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_INIT   = 3'd1;
   localparam logic [2:0] S_CORDIC = 3'd2;
   localparam logic [2:0] S_ROUND  = 3'd3;
   localparam logic [2:0] S_MUL    = 3'd4;
   localparam logic [2:0] S_DIV    = 3'd5;
   localparam logic [2:0] S_DONE   = 3'd6;

   localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(CORDIC_STEPS - 1);

   logic [2:0]        state_ff, state_in;
   logic [ITER_W-1:0] iter_ff, iter_in;

   assign req_ready = (state_ff == S_IDLE);

   // next state and commands
   always_comb begin
      state_in     = state_ff;
      iter_in      = iter_ff;
      cmd          = '0;
      cmd.iter     = iter_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.start = 1'b1;
               state_in  = S_INIT;
            end
         end
         S_INIT: begin
            cmd.init = 1'b1;
            iter_in  = '0;
            state_in = S_CORDIC;
         end
         S_CORDIC: begin
            cmd.step = 1'b1;
            iter_in  = iter_ff + 1'b1;
            if (iter_ff == ITER_LAST) begin
               state_in = S_ROUND;
            end
         end
         S_ROUND: begin
            cmd.round = 1'b1;
            state_in  = S_MUL;
         end
         S_MUL: begin
            cmd.mul  = 1'b1;
            state_in = S_DIV;
         end
         S_DIV: begin
            cmd.div  = 1'b1;
            state_in = S_DONE;
         end
         S_DONE: begin
            // wait while the previous response is still held
            if (!status.out_busy) begin
               cmd.load_out = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         iter_ff  <= '0;
      end else begin
         state_ff <= state_in;
         iter_ff  <= iter_in;
      end
   end

endmodule

FILE: src/lfp_dp.sv
// datapath: centroid, shared cordic step, pd term and drive saturation
`include "assert_macros.svh"

module lfp_dp
   import lfp_pkg::*;
#(
   parameter int SENSOR_COUNT = 7
)(
   input  logic                       clock,
   input  logic                       reset,
   input  lfp_cfg_type                cfg,
   input  lfp_cmd_type                cmd,
   output lfp_status_type             status,
   input  logic [SENSOR_W-1:0]        req_sensor_bits,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic signed [DRIVE_W-1:0]  rsp_left_drive,
   output logic signed [DRIVE_W-1:0]  rsp_right_drive,
   output logic signed [ANGLE_W-1:0]  rsp_angle_error,
   output logic                       rsp_junction_seen,
   output logic                       rsp_left_branch,
   output logic                       rsp_right_branch,
   output logic                       rsp_no_line
);

   // sensors at bit SENSOR_COUNT and above read as unlit
   localparam int USED = (SENSOR_COUNT < SENSOR_W) ? SENSOR_COUNT : SENSOR_W;
   localparam logic [SENSOR_W-1:0] LIT_MASK = SENSOR_W'((1 << USED) - 1);
   localparam logic RBR_ON = (SENSOR_COUNT <= SENSOR_W);
   localparam logic [2:0] RBR_IDX = 3'((SENSOR_COUNT <= SENSOR_W) ? SENSOR_COUNT - 1 : 0);

   localparam logic signed [Z_W-1:0]     Z_HALF   = Z_W'(128);
   localparam logic signed [Z_W-1:0]     Z_HI     = Z_W'(ANGLE_LIMIT);
   localparam logic signed [Z_W-1:0]     Z_LO     = -Z_HI;
   localparam logic signed [ANGLE_W-1:0] ANG_HI   = ANGLE_W'(ANGLE_LIMIT);
   localparam logic signed [ANGLE_W-1:0] ANG_LO   = -ANG_HI;
   localparam logic signed [WIDE_W-1:0]  DRV_HI   = WIDE_W'(DRIVE_LIMIT);
   localparam logic signed [WIDE_W-1:0]  DRV_LO   = -DRV_HI;
   localparam logic signed [PD_W-1:0]    PD_BIAS  = PD_W'(255);

   logic [SENSOR_W-1:0]        bits_ff;
   logic [COUNT_W-1:0]         count_ff;
   logic signed [CORDIC_W-1:0] x_ff, y_ff;
   logic signed [Z_W-1:0]      z_ff;
   logic signed [ANGLE_W-1:0]  angle_ff;
   logic signed [PPROD_W-1:0]  pprod_ff;
   logic signed [DPROD_W-1:0]  dprod_ff;
   logic signed [DELTA_W-1:0]  delta_ff;
   logic signed [ANGLE_W-1:0]  prev_angle_ff, prev_angle_in;
   logic                       have_prev_ff, have_prev_in;
   logic                       rsp_valid_ff, rsp_valid_in;

   logic [SENSOR_W-1:0]        rev_c;
   logic [COUNT_W-1:0]         count_c;
   logic [SUM_W-1:0]           sum_c;
   logic [31:0]                x0_c;
   logic signed [31:0]         y0_c;
   logic signed [CORDIC_W-1:0] xs_c, ys_c;
   logic signed [Z_W-1:0]      zsh_c;
   logic signed [ANGLE_W-1:0]  angle_c;
   logic                       junction_c;
   logic signed [DANG_W-1:0]   dang_c;
   logic signed [PPROD_W-1:0]  pprod_c;
   logic signed [DPROD_W-1:0]  dprod_c;
   logic signed [PD_W-1:0]     t_c, t_adj_c, t_sh_c;
   logic signed [WIDE_W-1:0]   base_c, delta2_c, left_c, right_c;
   logic signed [DRIVE_W-1:0]  left_sat_c, right_sat_c;
   logic                       hist_clear_c;
   logic                       prev_ok_c;

   // bit order reversal
   always_comb begin
      for (int i = 0; i < SENSOR_W; i++) begin
         rev_c[i] = req_sensor_bits[SENSOR_W-1-i];
      end
   end

   // lit count and index sum
   always_comb begin
      count_c = '0;
      sum_c   = '0;
      for (int i = 0; i < SENSOR_W; i++) begin
         if (bits_ff[i]) begin
            count_c = count_c + 1'b1;
            sum_c   = sum_c + SUM_W'(i);
         end
      end
   end

   // cordic start vector, scaled by 65536
   assign x0_c = {{(32-COUNT_W){1'b0}}, count_c} * 32'd16384000;
   assign y0_c = ($signed({{(32-SUM_W){1'b0}}, sum_c}) * 32'sd14
                - $signed({{(32-COUNT_W){1'b0}}, count_c}) * 32'sd49) <<< 16;

   // shifted terms for one vectoring step
   assign xs_c = x_ff >>> cmd.iter;
   assign ys_c = y_ff >>> cmd.iter;

   // round to 1/256 degree and saturate, empty line gives zero
   assign zsh_c = (z_ff + Z_HALF) >>> 8;
   always_comb begin
      if (count_ff == '0) begin
         angle_c = '0;
      end else if (zsh_c > Z_HI) begin
         angle_c = Z_HI[ANGLE_W-1:0];
      end else if (zsh_c < Z_LO) begin
         angle_c = Z_LO[ANGLE_W-1:0];
      end else begin
         angle_c = zsh_c[ANGLE_W-1:0];
      end
   end

   assign junction_c = (count_ff > {1'b0, cfg.junction_threshold});

   // pd products
   assign dang_c  = have_prev_ff ? (DANG_W'(prev_angle_ff) - DANG_W'(angle_ff)) : '0;
   assign pprod_c = $signed({1'b0, cfg.gain_p}) * angle_ff;
   assign dprod_c = $signed({1'b0, cfg.gain_d}) * dang_c;

   // difference divided by 256, truncating toward zero
   assign t_c     = PD_W'(pprod_ff) - PD_W'(dprod_ff);
   assign t_adj_c = t_c[PD_W-1] ? (t_c + PD_BIAS) : t_c;
   assign t_sh_c  = t_adj_c >>> 8;

   // drive sums and saturation
   assign base_c   = WIDE_W'($signed(cfg.base_speed));
   assign delta2_c = WIDE_W'(delta_ff) <<< 1;
   assign left_c   = base_c - delta2_c;
   assign right_c  = base_c + delta2_c;

   always_comb begin
      if (left_c > DRV_HI) begin
         left_sat_c = DRV_HI[DRIVE_W-1:0];
      end else if (left_c < DRV_LO) begin
         left_sat_c = DRV_LO[DRIVE_W-1:0];
      end else begin
         left_sat_c = left_c[DRIVE_W-1:0];
      end
      if (right_c > DRV_HI) begin
         right_sat_c = DRV_HI[DRIVE_W-1:0];
      end else if (right_c < DRV_LO) begin
         right_sat_c = DRV_LO[DRIVE_W-1:0];
      end else begin
         right_sat_c = right_c[DRIVE_W-1:0];
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         bits_ff <= (cfg.reverse_bits ? rev_c : req_sensor_bits) & LIT_MASK;
      end
      if (cmd.init) begin
         count_ff <= count_c;
         x_ff     <= x0_c[CORDIC_W-1:0];
         y_ff     <= y0_c[CORDIC_W-1:0];
         z_ff     <= '0;
      end else if (cmd.step) begin
         if (!y_ff[CORDIC_W-1]) begin
            x_ff <= x_ff + ys_c;
            y_ff <= y_ff - xs_c;
            z_ff <= z_ff + $signed(atan_entry(cmd.iter));
         end else begin
            x_ff <= x_ff - ys_c;
            y_ff <= y_ff + xs_c;
            z_ff <= z_ff - $signed(atan_entry(cmd.iter));
         end
      end
      if (cmd.round) begin
         angle_ff <= angle_c;
      end
      if (cmd.mul) begin
         pprod_ff <= pprod_c;
         dprod_ff <= dprod_c;
      end
      if (cmd.div) begin
         delta_ff <= junction_c ? '0 : t_sh_c[DELTA_W-1:0];
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp_left_drive    <= left_sat_c;
         rsp_right_drive   <= right_sat_c;
         rsp_angle_error   <= angle_ff;
         rsp_junction_seen <= junction_c;
         rsp_left_branch   <= junction_c && (bits_ff[1:0] != 2'b00);
         rsp_right_branch  <= junction_c && RBR_ON && bits_ff[RBR_IDX];
         rsp_no_line       <= (count_ff == '0);
      end
   end

   // heading history, cleared at a junction
   always_comb begin
      prev_angle_in = prev_angle_ff;
      have_prev_in  = have_prev_ff;
      if (cmd.div) begin
         if (junction_c) begin
            prev_angle_in = '0;
            have_prev_in  = 1'b0;
         end else begin
            prev_angle_in = angle_ff;
            have_prev_in  = 1'b1;
         end
      end
   end

   // response valid flag
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_angle_ff <= '0;
         have_prev_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         prev_angle_ff <= prev_angle_in;
         have_prev_ff  <= have_prev_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign status.out_busy = rsp_valid_ff && !rsp_ready;

   // history checks
   assign hist_clear_c = !have_prev_ff && (prev_angle_ff == '0);
   assign prev_ok_c    = (prev_angle_ff <= ANG_HI) && (prev_angle_ff >= ANG_LO);

   // never overwrite a response that is still held
   `ASSERT_IMPLIES(a_no_overwrite, clock, reset, cmd.load_out, !(rsp_valid_ff && !rsp_ready))
   // a junction always leaves an empty history
   `ASSERT_NEXT(a_junction_clears, clock, reset, cmd.div && junction_c, hist_clear_c)
   // stored heading stays within the saturation limits
   `ASSERT_IMPLIES(a_prev_range, clock, reset, 1'b1, prev_ok_c)

endmodule
